// ===== sv/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and codes of the linear probing hash table: the request and
// response payloads, the stored entry and the request and status codes.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_DUP  = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [31:0] key_hash;
    logic [31:0] key_id;
    logic [31:0] handler;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] handler_out;
    logic [7:0]  slot;
  } rsp_t;

  // one slot of the table memory
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] handler;
  } entry_t;

endpackage

// ===== sv/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing hash table with linear probing. Maps a key identity to a
// handler word; inserts stop at half load, duplicates are flagged.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                payload
//   request   in          in_valid_i / in_ready_o  in_req_i   (lpht_pkg::req_t)
//   response  out         out_valid_o / out_ready_i out_rsp_o (lpht_pkg::rsp_t)
//
// one request at a time: the request is accepted, the home slot divider
// runs, the first read is issued, then one memory read per probed slot,
// then the response is posted; a refused insert on a full table goes
// straight to the response. the single port slot memory sets the probe rate.
// after reset a clearing pass writes every slot before the first request is
// taken. a response waiting at the output does not block the next request;
// a finished one waits in place while the output is full.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int SLOTS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lpht_pkg::req_t   in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lpht_pkg::rsp_t   out_rsp_o
);

  import lpht_pkg::*;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int STEP_W = IDX_W + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HOME  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]        state_d, state_q;
  req_t              req_q;
  rsp_t              res_d, res_q;
  rsp_t              out_d, out_q;
  logic              out_valid_d, out_valid_q;
  logic [IDX_W-1:0]  idx_d, idx_q;
  logic [IDX_W-1:0]  idx_next;
  logic [STEP_W-1:0] steps_d, steps_q;
  logic [STEP_W-1:0] steps_inc;
  logic [IDX_W-1:0]  count_d, count_q;

  logic              accept;
  logic              table_full;
  logic              home_start;
  logic              home_done;
  logic [IDX_W-1:0]  home_slot;

  logic              mem_en;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_addr;
  entry_t            mem_wdata;
  entry_t            mem_rdata;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign table_full = (count_q >= IDX_W'(SLOTS / 2));
  assign home_start = accept & ~((in_req_i.req_type == REQ_INSERT) & table_full);

  assign idx_next  = (idx_q == IDX_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
  assign steps_inc = steps_q + 1'b1;

  lpht_home #(
    .SLOTS(SLOTS)
  ) u_home (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(home_start),
    .hash_i (in_req_i.key_hash),
    .done_o (home_done),
    .slot_o (home_slot)
  );

  lpht_mem #(
    .SLOTS(SLOTS)
  ) u_mem (
    .clk_i  (clk_i),
    .en_i   (mem_en),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    steps_d     = steps_q;
    count_d     = count_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = idx_q;
    mem_wdata   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
        idx_d  = idx_next;
        if (idx_q == IDX_W'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_d = '{status: ST_MISS, handler_out: '0, slot: '0};
          if (home_start) begin
            state_d = S_HOME;
          end else begin
            res_d.status = ST_FULL;
            state_d      = S_RESP;
          end
        end
      end
      S_HOME: begin
        if (home_done) begin
          idx_d   = home_slot;
          steps_d = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        mem_en  = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!mem_rdata.valid) begin
          if (req_q.req_type == REQ_INSERT) begin
            mem_en       = 1'b1;
            mem_we       = 1'b1;
            mem_wdata    = '{valid: 1'b1, key: req_q.key_id, handler: req_q.handler};
            count_d      = count_q + 1'b1;
            res_d.status = ST_OK;
            res_d.slot   = 8'(idx_q);
          end
          state_d = S_RESP;
        end else if (mem_rdata.key == req_q.key_id) begin
          if (req_q.req_type == REQ_INSERT) begin
            res_d.status = ST_DUP;
          end else begin
            res_d.status      = ST_OK;
            res_d.handler_out = mem_rdata.handler;
            res_d.slot        = 8'(idx_q);
          end
          state_d = S_RESP;
        end else if (steps_inc == STEP_W'(SLOTS)) begin
          // walked every slot without an empty one
          if (req_q.req_type == REQ_INSERT) begin
            res_d.status = ST_FULL;
          end
          state_d = S_RESP;
        end else begin
          mem_en   = 1'b1;
          mem_addr = idx_next;
          idx_d    = idx_next;
          steps_d  = steps_inc;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      steps_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      steps_q     <= steps_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== sv/lpht_home.sv =====
// ----------------------------------------------------------------------------
// lpht_home
// Home slot unit: key_hash modulo SLOTS through a reciprocal multiply, a
// quotient back-multiply and one correcting subtract.
// ----------------------------------------------------------------------------
module lpht_home #(
  parameter int SLOTS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                hash_i,
  output logic                       done_o,
  output logic [$clog2(SLOTS)-1:0]   slot_o
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int SHIFT = 32 + IDX_W;
  // floor(2^SHIFT / SLOTS) lies in [2^32, 2^33)
  localparam logic [32:0] RECIP = 33'((65'd1 << SHIFT) / 65'(SLOTS));

  logic [64:0]      prod_d, prod_q;
  logic [31:0]      hash1_q, hash2_q;
  logic [31:0]      quo;
  logic [31:0]      qs_d, qs_q;
  logic [32:0]      rem_raw;
  logic [32:0]      rem_fix;
  logic [IDX_W-1:0] slot_d, slot_q;
  logic             v1_q, v2_q, v3_q;

  assign prod_d = 65'(hash_i) * 65'(RECIP);

  // estimated quotient is exact or one low
  assign quo  = 32'(prod_q >> SHIFT);
  assign qs_d = 32'(quo * 32'(SLOTS));

  assign rem_raw = {1'b0, hash2_q} - {1'b0, qs_q};
  assign rem_fix = (rem_raw >= 33'(SLOTS)) ? rem_raw - 33'(SLOTS) : rem_raw;
  assign slot_d  = IDX_W'(rem_fix);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    hash1_q <= hash_i;
    qs_q    <= qs_d;
    hash2_q <= hash1_q;
    slot_q  <= slot_d;
  end

  assign done_o = v3_q;
  assign slot_o = slot_q;

endmodule

// ===== sv/lpht_mem.sv =====
// ----------------------------------------------------------------------------
// lpht_mem
// Single port slot memory holding valid mark, key and handler of each slot.
// Registered read data.
// ----------------------------------------------------------------------------
module lpht_mem #(
  parameter int SLOTS = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(SLOTS)-1:0] addr_i,
  input  lpht_pkg::entry_t         wdata_i,
  output lpht_pkg::entry_t         rdata_o
);

  import lpht_pkg::*;

  entry_t mem [SLOTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
